// ----- rtl/okle_pkg.sv -----
// Shared types and codes for the ordered key list engine.
package okle_pkg;

  localparam int unsigned CmdW    = 3;
  localparam int unsigned KeyW    = 27;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OutCntW = 7;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_DELETE    = 3'd2,
    CMD_SEARCH    = 3'd3,
    CMD_DUMP      = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FOUND     = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0] command;
    logic [KeyW-1:0] key;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    entry_key;
    logic [OutCntW-1:0] entry_count;
    logic               last;
  } out_t;

  // Store port enables.
  typedef struct packed {
    logic rd;
    logic key_we;
    logic nxt_we;
  } store_en_t;

endpackage

// ----- rtl/okle_store.sv -----
// Node store: key memory and next-pointer memory, registered read.
module okle_store #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic                          clk_i,
  input  okle_pkg::store_en_t           en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  input  logic [AW-1:0]                 key_waddr_i,
  input  logic [okle_pkg::KeyW-1:0]     key_wdata_i,
  input  logic [AW-1:0]                 nxt_waddr_i,
  input  logic [AW-1:0]                 nxt_wdata_i,
  output logic [okle_pkg::KeyW-1:0]     key_rdata_o,
  output logic [AW-1:0]                 nxt_rdata_o
);

  logic [okle_pkg::KeyW-1:0] key_mem [Depth];
  logic [AW-1:0]             nxt_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i.key_we) begin
      key_mem[key_waddr_i] <= key_wdata_i;
    end
    if (en_i.rd) begin
      key_rdata_o <= key_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.nxt_we) begin
      nxt_mem[nxt_waddr_i] <= nxt_wdata_i;
    end
    if (en_i.rd) begin
      nxt_rdata_o <= nxt_mem[rd_addr_i];
    end
  end

endmodule

// ----- rtl/ordered_key_list_engine_core.sv -----
// Ordered key list engine: linked list of keys kept in a node store.
// Steps: insert goes through S_INS_WR to S_RESP (through S_POP first once fresh
//   slots are used up and a slot is popped from the free list); search/delete walk
//   one node per cycle, up to count nodes, and delete then unlinks and frees the node.
// Throughput: one item at a time; the next item is taken the cycle after the
//   last result of the current one is registered; dump emits one entry per
//   cycle unless stalled.
// Reset: list empty, counters and pointers cleared; store contents undefined,
//   no clearing pass (slots handed out from a fresh-slot counter first).
module ordered_key_list_engine_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  okle_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output okle_pkg::out_t out_data_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_INS_WR,
    S_WALK,
    S_DEL_UNLINK,
    S_DEL_FREE,
    S_RESP
  } state_e;

  state_e state_q;

  // list bookkeeping
  logic [AW-1:0] head_q, tail_q, free_head_q;
  logic [CW-1:0] count_q;     // stored entries
  logic [CW-1:0] fresh_q;     // slots ever handed out

  // per-item working registers
  logic [okle_pkg::CmdW-1:0]    cmd_q;
  logic [okle_pkg::KeyW-1:0]    key_q;
  logic [AW-1:0]                slot_q, cur_q, prev_q, succ_q;
  logic [CW-1:0]                idx_q;
  logic [okle_pkg::StatusW-1:0] res_q;

  logic           out_valid_q;
  okle_pkg::out_t out_data_q;

  // store ports
  okle_pkg::store_en_t       st_en;
  logic [AW-1:0]             st_rd_addr, st_nxt_waddr, st_nxt_wdata;
  logic [okle_pkg::KeyW-1:0] key_rd;
  logic [AW-1:0]             nxt_rd;

  logic in_fire, out_free, list_full, list_empty, fresh_left;
  logic is_ins, is_walk, start_walk, start_pop;
  logic hit, at_end, is_dump, advance, emit;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign list_full  = (count_q == CW'(CAPACITY));
  assign list_empty = (count_q == '0);
  assign fresh_left = (fresh_q != CW'(CAPACITY));

  assign is_ins  = (in_data_i.command == okle_pkg::CMD_INS_FRONT) ||
                   (in_data_i.command == okle_pkg::CMD_INS_BACK);
  assign is_walk = (in_data_i.command == okle_pkg::CMD_DELETE) ||
                   (in_data_i.command == okle_pkg::CMD_SEARCH) ||
                   (in_data_i.command == okle_pkg::CMD_DUMP);

  assign start_walk = in_fire && is_walk && !list_empty;
  assign start_pop  = in_fire && is_ins && !list_full && !fresh_left;

  // node under the walk pointer is valid in S_WALK (its read was issued on entry or on the last advance)
  assign hit     = (key_rd == key_q);
  assign at_end  = ((idx_q + CW'(1)) == count_q);
  assign is_dump = (cmd_q == okle_pkg::CMD_DUMP);
  assign advance = (state_q == S_WALK) && !at_end &&
                   (is_dump ? out_free : !hit);

  // a result is loaded into the output register this cycle
  assign emit = (((state_q == S_WALK) && is_dump) || (state_q == S_RESP)) && out_free;

  // Store control. The FSM never reads in a cycle that writes, and every
  // write lands before the next read is issued, so no forwarding is needed.
  always_comb begin
    st_en        = '0;
    st_rd_addr   = nxt_rd;
    st_nxt_waddr = slot_q;
    st_nxt_wdata = head_q;
    if (start_walk) begin
      st_en.rd   = 1'b1;
      st_rd_addr = head_q;
    end else if (start_pop) begin
      st_en.rd   = 1'b1;
      st_rd_addr = free_head_q;
    end else if (advance) begin
      st_en.rd   = 1'b1;
    end
    unique case (state_q)
      S_INS_WR: begin
        st_en.key_we = 1'b1;
        if (cmd_q == okle_pkg::CMD_INS_FRONT) begin
          st_en.nxt_we = 1'b1;              // new node points at old head
        end else begin
          st_en.nxt_we = !list_empty;       // old tail points at new node
          st_nxt_waddr = tail_q;
          st_nxt_wdata = slot_q;
        end
      end
      S_DEL_UNLINK: begin
        st_en.nxt_we = (idx_q != '0);       // bypass the node from its predecessor
        st_nxt_waddr = prev_q;
        st_nxt_wdata = succ_q;
      end
      S_DEL_FREE: begin
        st_en.nxt_we = 1'b1;                // push freed node on the free list
        st_nxt_waddr = cur_q;
        st_nxt_wdata = free_head_q;
      end
      default: ;
    endcase
  end

  okle_store #(
    .Depth(CAPACITY)
  ) u_store (
    .clk_i       (clk_i),
    .en_i        (st_en),
    .rd_addr_i   (st_rd_addr),
    .key_waddr_i (slot_q),
    .key_wdata_i (key_q),
    .nxt_waddr_i (st_nxt_waddr),
    .nxt_wdata_i (st_nxt_wdata),
    .key_rdata_o (key_rd),
    .nxt_rdata_o (nxt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      free_head_q <= '0;
      count_q     <= '0;
      fresh_q     <= '0;
      cmd_q       <= '0;
      key_q       <= '0;
      slot_q      <= '0;
      cur_q       <= '0;
      prev_q      <= '0;
      succ_q      <= '0;
      idx_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q <= in_data_i.command;
            key_q <= in_data_i.key;
            idx_q <= '0;
            cur_q <= head_q;
            if (is_ins) begin
              if (list_full) begin
                res_q   <= okle_pkg::ST_FULL;
                state_q <= S_RESP;
              end else if (fresh_left) begin
                slot_q  <= AW'(fresh_q);
                fresh_q <= fresh_q + CW'(1);
                state_q <= S_INS_WR;
              end else begin
                state_q <= S_POP;
              end
            end else if (is_walk) begin
              if (!list_empty) begin
                state_q <= S_WALK;
              end else begin
                res_q   <= (in_data_i.command == okle_pkg::CMD_DUMP) ?
                           okle_pkg::ST_EMPTY : okle_pkg::ST_NOT_FOUND;
                state_q <= S_RESP;
              end
            end
            // undefined command codes are dropped
          end
        end
        S_POP: begin
          slot_q      <= free_head_q;
          free_head_q <= nxt_rd;
          state_q     <= S_INS_WR;
        end
        S_INS_WR: begin
          if (cmd_q == okle_pkg::CMD_INS_FRONT) begin
            head_q <= slot_q;
            if (list_empty) begin
              tail_q <= slot_q;
            end
          end else begin
            tail_q <= slot_q;
            if (list_empty) begin
              head_q <= slot_q;
            end
          end
          count_q <= count_q + CW'(1);
          res_q   <= okle_pkg::ST_INSERTED;
          state_q <= S_RESP;
        end
        S_WALK: begin
          if (advance) begin
            prev_q <= cur_q;
            cur_q  <= nxt_rd;
            idx_q  <= idx_q + CW'(1);
          end
          if (is_dump) begin
            if (out_free) begin
              out_data_q  <= '{status:      okle_pkg::ST_ENTRY,
                               entry_key:   key_rd,
                               entry_count: okle_pkg::OutCntW'(count_q),
                               last:        at_end};
              if (at_end) begin
                state_q <= S_IDLE;
              end
            end
          end else if (hit) begin
            if (cmd_q == okle_pkg::CMD_DELETE) begin
              succ_q  <= nxt_rd;
              state_q <= S_DEL_UNLINK;
            end else begin
              res_q   <= okle_pkg::ST_FOUND;
              state_q <= S_RESP;
            end
          end else if (at_end) begin
            res_q   <= okle_pkg::ST_NOT_FOUND;
            state_q <= S_RESP;
          end
        end
        S_DEL_UNLINK: begin
          if (idx_q == '0) begin
            head_q <= succ_q;
          end
          if (at_end) begin
            tail_q <= prev_q;
          end
          count_q <= count_q - CW'(1);
          state_q <= S_DEL_FREE;
        end
        S_DEL_FREE: begin
          free_head_q <= cur_q;
          res_q       <= okle_pkg::ST_DELETED;
          state_q     <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_data_q  <= '{status:      res_q,
                             entry_key:   '0,
                             entry_count: okle_pkg::OutCntW'(count_q),
                             last:        1'b1};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // count never exceeds capacity nor the number of slots handed out
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CW'(CAPACITY)) && (count_q <= fresh_q))
    else $error("stored count out of bounds");

  // store is never read and written in the same cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_en.rd |-> !(st_en.key_we || st_en.nxt_we))
    else $error("store read overlaps a write");

  // only dump entries may be followed by more results of the same item
  a_last_only_dump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> (out_data_o.status == okle_pkg::ST_ENTRY))
    else $error("non-final result with non-entry status");

  // an insert bumps the count by exactly one
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_WR) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not bump count");

endmodule

// ----- sim/okle_list_checker.sv -----
// Checker for the ordered key list engine: tracks the list, predicts results, compares them.
module okle_list_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  okle_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  okle_pkg::out_t out_data_i,
  output int             mismatch_cnt_o,
  output int             pending_o
);
  import okle_pkg::*;

  logic [KeyW-1:0] list_keys[$];   // front of the list at index 0
  out_t            expected_q[$];
  int              mismatches = 0;
  int              waiting    = 0;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = waiting;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t okle check: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Count field is taken after the list has been updated.
  task automatic queue_result(input status_e st, input logic [KeyW-1:0] k,
                              input logic is_last);
    out_t r;
    r.status      = st;
    r.entry_key   = k;
    r.entry_count = OutCntW'(list_keys.size());
    r.last        = is_last;
    expected_q.push_back(r);
  endtask

  task automatic predict_list_op(input in_t item);
    int hit;
    hit = -1;
    for (int i = 0; i < list_keys.size(); i++) begin
      if (hit < 0 && list_keys[i] == item.key) hit = i;
    end
    case (item.command)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (list_keys.size() >= CAPACITY) begin
          queue_result(ST_FULL, '0, 1'b1);
        end else begin
          if (item.command == CMD_INS_FRONT) list_keys.push_front(item.key);
          else list_keys.push_back(item.key);
          queue_result(ST_INSERTED, '0, 1'b1);
        end
      end
      CMD_DELETE: begin
        if (hit < 0) begin
          queue_result(ST_NOT_FOUND, '0, 1'b1);
        end else begin
          list_keys.delete(hit);
          queue_result(ST_DELETED, '0, 1'b1);
        end
      end
      CMD_SEARCH: begin
        queue_result((hit < 0) ? ST_NOT_FOUND : ST_FOUND, '0, 1'b1);
      end
      CMD_DUMP: begin
        if (list_keys.size() == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_keys.size(); i++) begin
            queue_result(ST_ENTRY, list_keys[i], i == list_keys.size() - 1);
          end
        end
      end
      default: ;  // unused command codes: no result, no change
    endcase
  endtask

  // A result never leaves in the edge that accepts its item, so the output
  // side is handled first within an edge.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      list_keys.delete();
      expected_q.delete();
      waiting = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_data_i.status), '0);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.status !== want.status)
            report_mismatch("status", 32'(out_data_i.status), 32'(want.status));
          if (out_data_i.entry_key !== want.entry_key)
            report_mismatch("entry_key", 32'(out_data_i.entry_key),
                            32'(want.entry_key));
          if (out_data_i.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_data_i.entry_count),
                            32'(want.entry_count));
          if (out_data_i.last !== want.last)
            report_mismatch("last", 32'(out_data_i.last), 32'(want.last));
        end
      end
      if (in_valid_i && in_ready_i) predict_list_op(in_data_i);
      waiting = expected_q.size();
    end
  end

endmodule

// ----- sim/tb_ordered_key_list_engine_core.sv -----
// Testbench top for the ordered key list engine: stimulus, output pacing and verdict.
module tb_ordered_key_list_engine_core;
  import okle_pkg::*;

  localparam int unsigned CAPACITY  = 64;
  localparam int unsigned POOL_SIZE = 16;
  localparam int unsigned LONG_HOLD = 400;   // cycles the receiver holds off
  localparam int unsigned TAIL_WAIT = 200;   // cycles after the last result

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;
  int   mismatch_cnt;
  int   pending;

  // Sender pacing: items go out in bursts, with idle gaps between bursts.
  int   burst_left = 0;
  // Long receiver hold-off is requested by bumping hold_req.
  int   hold_req   = 0;
  int   hold_done  = 0;

  // Keys reused across the run so deletes and searches actually hit.
  logic [KeyW-1:0] key_pool[POOL_SIZE];

  ordered_key_list_engine_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  okle_list_checker #(
    .CAPACITY(CAPACITY)
  ) i_list_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("ordered_key_list_engine_core: mismatch");
    $finish;
  end

  // Output side: ready pattern changes mode every so often. Modes cover
  // always-ready, coin-flip, a fixed periodic stall and rare stalls.
  initial begin
    int rx_mode;
    int rx_tick;
    rx_mode   = 0;
    rx_tick   = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        // Long hold-off: block backs up and should stop taking items.
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done++;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= (rx_tick % 4) != 3;
          default: out_ready <= $urandom_range(0, 7) != 0;
        endcase
        rx_tick++;
        if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
      end
    end
  end

  function automatic logic [KeyW-1:0] pick_key();
    if ($urandom_range(0, 4) != 0) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KeyW'($urandom());
  endfunction

  // Present one item and hold it until the transfer happens. Opens a gap
  // first whenever the current burst is used up.
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, key: key};
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Stop offering items until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One random item; percentages steer the list size up or down.
  task automatic send_random(input int ins_pct, input int del_pct);
    int                r;
    logic [CmdW-1:0]   cmd;
    r = $urandom_range(0, 99);
    if (r < ins_pct) cmd = $urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT;
    else if (r < ins_pct + del_pct) cmd = CMD_DELETE;
    else if (r < 90) cmd = CMD_SEARCH;
    else if (r < 97) cmd = CMD_DUMP;
    else cmd = CmdW'($urandom_range(int'(CMD_DUMP) + 1, (1 << CmdW) - 1));
    send_item(cmd, pick_key());
  endtask

  initial begin
    int c;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;

    key_pool[0] = '0;
    key_pool[1] = '1;            // above the nominal key range
    key_pool[2] = KeyW'(99999999);
    for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = KeyW'($urandom_range(0, 99999999));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-list cases first.
    send_item(CMD_DUMP, '0);
    send_item(CMD_DELETE, KeyW'(5));
    send_item(CMD_SEARCH, KeyW'(5));
    // Build a short list with extreme keys and a duplicate.
    send_item(CMD_INS_FRONT, '0);
    send_item(CMD_INS_BACK, '1);
    send_item(CMD_INS_FRONT, KeyW'(99999999));
    send_item(CMD_INS_BACK, '0);
    send_item(CMD_SEARCH, '1);
    send_item(CMD_SEARCH, KeyW'(12345));
    send_item(CMD_DUMP, '1);                 // key field is don't-care on dump
    // Delete of a duplicated key must take the one nearest the front.
    send_item(CMD_DELETE, '0);
    send_item(CMD_DUMP, '0);
    send_item(CMD_DELETE, KeyW'(777));
    // Unused command codes: dropped with no result.
    for (c = int'(CMD_DUMP) + 1; c < (1 << CmdW); c++) send_item(CmdW'(c), '1);
    send_item(CMD_DELETE, KeyW'(99999999));  // front entry
    send_item(CMD_DELETE, '1);
    send_item(CMD_DELETE, '0);               // list empty again
    send_item(CMD_DUMP, '0);
    wait_drained();

    // Mixed traffic.
    repeat (55) send_random(45, 30);

    // Fill past capacity so inserts get rejected.
    repeat (CAPACITY + 4) begin
      send_item($urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT, pick_key());
    end

    // Long hold-off on the output while full-list dumps keep coming.
    hold_req++;
    send_item(CMD_DUMP, '0);
    send_item(CMD_SEARCH, pick_key());
    send_item(CMD_DUMP, '0);
    send_item(CMD_INS_BACK, pick_key());
    send_item(CMD_DUMP, '0);
    wait_drained();

    // Shrink the list, mostly deletes.
    repeat (80) send_random(15, 65);
    wait_drained();

    // Mixed traffic again from wherever the list ended up.
    repeat (25) send_random(45, 30);

    wait_drained();
    repeat (TAIL_WAIT) @(negedge clk);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("ordered_key_list_engine_core: match");
    end else begin
      $display("ordered_key_list_engine_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/okle_pkg.sv
rtl/okle_store.sv
rtl/ordered_key_list_engine_core.sv
sim/okle_list_checker.sv
sim/tb_ordered_key_list_engine_core.sv
